// ===== design/spk_pkg.sv =====
// ----------------------------------------------------------------------------
// spk_pkg
// Types and constants shared by the stream message packetizer modules.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_W   = 64;
  localparam int unsigned KEEP_W   = 32;
  localparam int unsigned DEST_W   = 16;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned IN_DATA_W  = 400;
  localparam int unsigned OUT_DATA_W = 336;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef logic [LANES-1:0][LANE_W-1:0] word_t;

  typedef struct packed {
    op_t                op;
    logic [DEST_W-1:0]  dest_port;
    logic [FIELD_W-1:0] byte_count;
    logic [FIELD_W-1:0] msg_tag;
    logic [FIELD_W-1:0] msg_source;
    logic [FIELD_W-1:0] msg_seq;
    word_t              lanes;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [DEST_W-1:0]  dest;
    word_t              lanes;
    logic [KEEP_W-1:0]  keep;
    logic               last;
    logic [FIELD_W-1:0] seq;
    logic               run_end;
  } result_t;

  typedef struct packed {
    logic               has_first;
    logic               has_status;
    logic [FIELD_W-1:0] status_seq;
  } emit_t;

endpackage

// ===== design/spk_in_reg.sv =====
// ----------------------------------------------------------------------------
// spk_in_reg
// Input register: captures one word from the slave side and holds it
// until the core takes it.
// ----------------------------------------------------------------------------
module spk_in_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [spk_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,
  output logic                              item_valid,
  output spk_pkg::in_item_t                 item,
  input  logic                              take
);
  import spk_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     in_fire;

  assign in_tready = !valid_r || take;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op         <= op_t'(in_tuser);
      item_r.dest_port  <= in_tdata[15:0];
      item_r.byte_count <= in_tdata[47:16];
      item_r.msg_tag    <= in_tdata[79:48];
      item_r.msg_source <= in_tdata[111:80];
      item_r.msg_seq    <= in_tdata[143:112];
      item_r.lanes      <= in_tdata[399:144];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/spk_core.sv =====
// ----------------------------------------------------------------------------
// spk_core
// Message state and result formation: header, payload words with keep and
// packet split, and completion status.
// ----------------------------------------------------------------------------
module spk_core #(
  parameter int unsigned WORD_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [spk_pkg::FIELD_W-1:0]   cfg_wr_data,
  input  spk_pkg::in_item_t             item,
  input  logic                          take,
  output spk_pkg::result_t              first,
  output spk_pkg::emit_t                emit
);
  import spk_pkg::*;

  localparam logic [FIELD_W-1:0] WB = FIELD_W'(WORD_BYTES);

  logic                busy_r, busy_nxt;
  logic [FIELD_W-1:0]  remain_r, remain_nxt;
  logic [FIELD_W-1:0]  wip_r, wip_nxt;
  logic [DEST_W-1:0]   dest_r, dest_nxt;
  logic [FIELD_W-1:0]  seq_r, seq_nxt;
  logic [FIELD_W-1:0]  max_r;

  logic [KEEP_W-1:0]   full_keep;
  logic [KEEP_W-1:0]   tail_keep;
  logic [FIELD_W-1:0]  wip_inc;
  logic                short_tail;
  logic                done;
  logic                split;

  assign full_keep  = ~({KEEP_W{1'b1}} << WORD_BYTES);
  assign tail_keep  = ~({KEEP_W{1'b1}} << remain_r[5:0]);
  assign wip_inc    = wip_r + 1'b1;
  assign short_tail = remain_r < WB;
  assign done       = remain_r <= WB;
  assign split      = wip_inc == max_r;

  always_comb begin
    busy_nxt   = busy_r;
    remain_nxt = remain_r;
    wip_nxt    = wip_r;
    dest_nxt   = dest_r;
    seq_nxt    = seq_r;
    first      = '0;
    emit       = '0;
    first.kind = KIND_WORD;
    case (item.op)
      OP_CMD: begin
        if (!busy_r) begin
          emit.has_first = 1'b1;
          first.dest     = item.dest_port;
          first.lanes[0] = {item.msg_tag, item.byte_count};
          first.lanes[1] = {item.msg_seq, item.msg_source};
          first.keep     = full_keep;
          dest_nxt       = item.dest_port;
          seq_nxt        = item.msg_seq;
          remain_nxt     = item.byte_count;
          if (item.byte_count == '0) begin
            first.last      = 1'b1;
            first.run_end   = 1'b0;
            emit.has_status = 1'b1;
            emit.status_seq = item.msg_seq;
            wip_nxt         = '0;
          end else begin
            first.last    = max_r == FIELD_W'(1);
            first.run_end = 1'b1;
            busy_nxt      = 1'b1;
            wip_nxt       = (max_r == FIELD_W'(1)) ? '0 : FIELD_W'(1);
          end
        end
      end
      OP_DATA: begin
        if (busy_r) begin
          emit.has_first = 1'b1;
          first.dest     = dest_r;
          first.lanes    = item.lanes;
          first.keep     = short_tail ? tail_keep : full_keep;
          first.last     = split || done;
          first.run_end  = !done;
          wip_nxt        = (split || done) ? '0 : wip_inc;
          remain_nxt     = short_tail ? '0 : remain_r - WB;
          if (done) begin
            busy_nxt        = 1'b0;
            remain_nxt      = '0;
            emit.has_status = 1'b1;
            emit.status_seq = seq_r;
          end
        end
      end
      default: begin
        emit.has_first = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      remain_r <= '0;
      wip_r    <= '0;
      dest_r   <= '0;
      seq_r    <= '0;
      max_r    <= '0;
    end else begin
      if (take) begin
        busy_r   <= busy_nxt;
        remain_r <= remain_nxt;
        wip_r    <= wip_nxt;
        dest_r   <= dest_nxt;
        seq_r    <= seq_nxt;
      end
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  a_busy_remain: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> remain_r != '0) else $error("busy with no bytes left");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (remain_r == '0 && wip_r == '0)) else $error("idle state not clean");
  a_wip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && max_r != '0) |-> wip_r < max_r) else $error("packet word count overran");

endmodule

// ===== design/spk_out_stage.sv =====
// ----------------------------------------------------------------------------
// spk_out_stage
// Result register with one pending status slot; drives the master side.
// ----------------------------------------------------------------------------
module spk_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  output logic                              take,
  input  spk_pkg::result_t                  first,
  input  spk_pkg::emit_t                    emit,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spk_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [spk_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);
  import spk_pkg::*;

  logic               valid_r, valid_nxt;
  logic               pend_r, pend_nxt;
  logic [FIELD_W-1:0] pend_seq_r, pend_seq_nxt;
  result_t            res_r, res_nxt;
  result_t            status;
  logic               room;
  logic               out_fire;

  assign room     = !pend_r && (!valid_r || out_tready);
  assign take     = item_valid && room;
  assign out_fire = valid_r && out_tready;

  always_comb begin
    status         = '0;
    status.kind    = KIND_STATUS;
    status.seq     = pend_seq_r;
    status.run_end = 1'b1;
  end

  always_comb begin
    valid_nxt    = valid_r;
    pend_nxt     = pend_r;
    pend_seq_nxt = pend_seq_r;
    res_nxt      = res_r;
    if (take && emit.has_first) begin
      valid_nxt    = 1'b1;
      res_nxt      = first;
      pend_nxt     = emit.has_status;
      pend_seq_nxt = emit.status_seq;
    end else if (out_fire) begin
      if (pend_r) begin
        res_nxt  = status;
        pend_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    pend_seq_r <= pend_seq_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.seq, res_r.keep, res_r.lanes, res_r.dest};
  assign out_tuser  = {res_r.run_end, res_r.kind};
  assign out_tlast  = res_r.last;

  a_pend_behind_word: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (valid_r && res_r.kind == KIND_WORD && !res_r.run_end))
    else $error("status pending without its final word");
  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && res_r.kind == KIND_STATUS) |-> (res_r.run_end && !res_r.last))
    else $error("status result malformed");
  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && pend_r) |=> (valid_r && res_r.kind == KIND_STATUS))
    else $error("pending status not presented");

endmodule

// ===== design/stream_message_packetizer.sv =====
// ----------------------------------------------------------------------------
// stream_message_packetizer
// Turns command/data words into a header, payload words and a status result.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (in_*): tuser selects command (0) or payload data (1). A
//   command opens a message and yields a header word; each payload word is
//   passed on tagged with the message's destination. Commands while a
//   message is open and data while idle are dropped.
//   Master side (out_*): tuser[0] is the result kind (word or status),
//   tuser[1] marks the last result of an input word; tlast is the packet
//   end, forced every max_packet_words words and at message end.
//   Config: cfg_wr_en/cfg_wr_data write max_packet_words (0 = no split).
// Path: the input register holds each word until the core takes it, and the
//   result register loads as the word is taken; the result is presented on
//   the master side from then on.
// Throughput: one word per cycle while out_tready is high; no input is taken
//   while the status result after a message's final word is pending behind
//   that word in the result register.
// Reset: clears message state, the register and both valid flags.
// Stall: while out_tready is low the result holds and in_tready falls once
//   the input register is full.
// ----------------------------------------------------------------------------
module stream_message_packetizer #(
  parameter int unsigned WORD_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [31:0]                       cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // dest_port, byte_count, msg_tag, msg_source, msg_seq, in_lane_0..3
  input  logic [spk_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_dest, out_lane_0..3, keep_mask, acked_seq
  output logic [spk_pkg::OUT_DATA_W-1:0]    out_tdata,
  // result_kind, run_end
  output logic [spk_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);
  import spk_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      take;
  result_t   first;
  emit_t     emit;

  spk_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  spk_core #(
    .WORD_BYTES (WORD_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .take        (take),
    .first       (first),
    .emit        (emit)
  );

  spk_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .take       (take),
    .first      (first),
    .emit       (emit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/tb_stream_message_packetizer.sv =====
// ----------------------------------------------------------------------------
// tb_stream_message_packetizer
// Self-checking bench for the stream message packetizer. Commands and payload
// words go in through the slave side with random gaps; a local model of the
// header, keep, tlast and status rules predicts every result on the master
// side. Results are checked field by field under random back-pressure, over
// several max_packet_words settings.
// ----------------------------------------------------------------------------
module tb_stream_message_packetizer;
  import spk_pkg::*;

  localparam int unsigned WB = 32;

  typedef struct {
    in_item_t item;
    bit       pause;
  } stim_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [31:0]           cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  stream_message_packetizer #(.WORD_BYTES(WB)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // packetizer model state
  logic               pk_busy = 1'b0;
  logic [32:0]        pk_left = '0;
  logic [31:0]        pk_words = '0;
  logic [DEST_W-1:0]  pk_dest = '0;
  logic [FIELD_W-1:0] pk_seq = '0;
  logic [31:0]        pk_max = '0;

  stim_t   pending_in[$];
  result_t out_words_due[$];
  longint  gen_words_left = 0;
  int      words_queued = 0;
  int      words_taken = 0;
  int      results_checked = 0;
  int      msgs_opened = 0;
  int      settings_used = 1;
  int      errors = 0;
  int      in_gap = 0;
  int      out_stall = 0;
  bit      idle_off = 1'b0;
  logic    in_took = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t rand_word();
    word_t w;
    for (int i = 0; i < LANES; i++) w[i] = {$urandom, $urandom};
    return w;
  endfunction

  task automatic packetize_item(input in_item_t it);
    result_t     r;
    logic [32:0] left;
    logic        done;
    if (it.op == OP_CMD) begin
      if (pk_busy) return;
      msgs_opened++;
      pk_dest = it.dest_port;
      pk_seq = it.msg_seq;
      pk_words = 32'd1;
      r = '0;
      r.kind = KIND_WORD;
      r.dest = pk_dest;
      r.lanes[0] = {it.msg_tag, it.byte_count};
      r.lanes[1] = {it.msg_seq, it.msg_source};
      r.keep = '1;
      if (it.byte_count == '0) begin
        r.last = 1'b1;
        r.run_end = 1'b0;
      end else begin
        r.last = (pk_words == pk_max);
        r.run_end = 1'b1;
        pk_left = {1'b0, it.byte_count};
        pk_busy = 1'b1;
      end
      if (r.last) pk_words = '0;
      out_words_due.push_back(r);
      if (it.byte_count != '0) return;
    end else begin
      if (!pk_busy) return;
      left = pk_left;
      r = '0;
      r.kind = KIND_WORD;
      r.dest = pk_dest;
      r.lanes = it.lanes;
      if (left < WB) begin
        r.keep = KEEP_W'((33'd1 << left) - 33'd1);
        pk_left = '0;
      end else begin
        r.keep = '1;
        pk_left = left - WB;
      end
      pk_words = pk_words + 32'd1;
      done = (left <= WB);
      r.last = (pk_words == pk_max) || done;
      r.run_end = !done;
      if (r.last) pk_words = '0;
      out_words_due.push_back(r);
      if (!done) return;
      pk_busy = 1'b0;
      pk_left = '0;
    end
    r = '0;
    r.kind = KIND_STATUS;
    r.seq = pk_seq;
    r.run_end = 1'b1;
    out_words_due.push_back(r);
  endtask

  // accept input words and check results
  always @(posedge clk) begin : mon_blk
    result_t got;
    result_t want;
    in_item_t it;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser[0]);
      got.run_end = out_tuser[1];
      got.dest = out_tdata[15:0];
      got.lanes = out_tdata[271:16];
      got.keep = out_tdata[303:272];
      got.seq = out_tdata[335:304];
      got.last = out_tlast;
      if (out_words_due.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d", got.kind));
      end else begin
        want = out_words_due.pop_front();
        results_checked++;
        check_field("kind", got.kind, want.kind);
        check_field("dest", got.dest, want.dest);
        for (int i = 0; i < LANES; i++)
          check_field($sformatf("lane%0d", i), got.lanes[i], want.lanes[i]);
        check_field("keep", got.keep, want.keep);
        check_field("tlast", got.last, want.last);
        check_field("acked_seq", got.seq, want.seq);
        check_field("run_end", got.run_end, want.run_end);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      it.op = op_t'(in_tuser);
      {it.lanes, it.msg_seq, it.msg_source, it.msg_tag, it.byte_count,
       it.dest_port} = in_tdata;
      packetize_item(it);
      words_taken++;
    end
  end

  // drive input words and output back-pressure
  always @(negedge clk) begin : drv_blk
    stim_t s;
    if (rst_n) begin
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
        out_stall = idle_off ? 0 : pick_gap();
      end
      if (!in_tvalid || in_took) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (pending_in.size() > 0 &&
                     !(pending_in[0].pause && out_words_due.size() > 0)) begin
          s = pending_in.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= s.item.op;
          in_tdata <= {s.item.lanes, s.item.msg_seq, s.item.msg_source,
                       s.item.msg_tag, s.item.byte_count, s.item.dest_port};
          in_gap = idle_off ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_cmd(input logic [15:0] dest, input logic [31:0] count,
                         input logic [31:0] tag, input logic [31:0] src,
                         input logic [31:0] seq, input bit pause);
    stim_t s;
    s.item = '0;
    s.item.op = OP_CMD;
    s.item.dest_port = dest;
    s.item.byte_count = count;
    s.item.msg_tag = tag;
    s.item.msg_source = src;
    s.item.msg_seq = seq;
    s.item.lanes = rand_word();
    s.pause = pause;
    if (gen_words_left == 0) gen_words_left = (longint'(count) + WB - 1) / WB;
    pending_in.push_back(s);
    words_queued++;
  endtask

  task automatic add_data(input word_t w, input bit pause);
    stim_t s;
    s.item = '0;
    s.item.op = OP_DATA;
    s.item.dest_port = $urandom;
    s.item.byte_count = $urandom;
    s.item.lanes = w;
    s.pause = pause;
    if (gen_words_left > 0) gen_words_left--;
    pending_in.push_back(s);
    words_queued++;
  endtask

  task automatic add_rand_cmd(input logic [31:0] count);
    add_cmd($urandom, count, $urandom, $urandom, $urandom,
            $urandom_range(0, 99) < 2);
  endtask

  task automatic close_message();
    while (gen_words_left > 0) add_data(rand_word(), 1'b0);
  endtask

  task automatic drain();
    while (words_taken != words_queued || out_words_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_words(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    pk_max = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= $urandom;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 7))
        0: return 32'd0;
        1: return 32'd1;
        2: return 32'd31;
        3: return 32'd32;
        4: return 32'd33;
        5: return 32'd63;
        6: return 32'd64;
        default: return 32'd65;
      endcase
    end
    if (r < 95) return $urandom_range(0, 200);
    return $urandom_range(300, 700);
  endfunction

  task automatic random_phase(input int target);
    int n;
    n = 0;
    while (n < target) begin
      if (gen_words_left == 0) begin
        if ($urandom_range(0, 99) < 10) begin
          add_data(rand_word(), 1'b0);
        end else begin
          add_rand_cmd(pick_count());
          n++;
        end
      end else if ($urandom_range(0, 99) < 8) begin
        add_cmd($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
      end else begin
        add_data(rand_word(), $urandom_range(0, 99) < 2);
        n++;
      end
    end
    close_message();
  endtask

  initial begin
    logic [31:0] settings[6];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: no split, reset value of the register
    add_data('1, 1'b0);
    add_cmd(16'hFFFF, 32'd0, '1, '1, '1, 1'b0);
    add_cmd(16'h0000, 32'd0, '0, '0, '0, 1'b1);
    add_rand_cmd(32'd1);
    add_data('1, 1'b0);
    add_rand_cmd(32'd32);
    add_data(rand_word(), 1'b0);
    add_rand_cmd(32'd33);
    add_data(rand_word(), 1'b0);
    add_cmd($urandom, '1, '1, '1, '1, 1'b0);
    add_data(rand_word(), 1'b0);
    add_rand_cmd(32'd31);
    add_data('0, 1'b0);
    add_rand_cmd(32'd64);
    close_message();
    add_data(rand_word(), 1'b0);
    drain();

    write_max_words(32'd1);
    add_rand_cmd(32'd70);
    close_message();
    add_rand_cmd(32'd0);
    drain();

    settings = '{32'hFFFF_FFFF, 32'd1, 32'd2, $urandom_range(3, 7), 32'd0, 32'd5};
    foreach (settings[i]) begin
      write_max_words(settings[i]);
      idle_off = (i == 1 || i == 4);
      random_phase(65);
      drain();
    end
    idle_off = 1'b0;

    // open the longest possible message and leave it open
    write_max_words(32'd2);
    add_rand_cmd(32'hFFFF_FFFF);
    repeat (5) add_data(rand_word(), 1'b0);
    drain();

    $display("run: %0d input words taken, %0d messages opened, %0d results checked",
             words_taken, msgs_opened, results_checked);
    $display("run: %0d max_packet_words settings, %0d mismatches",
             settings_used, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/spk_pkg.sv
design/spk_in_reg.sv
design/spk_core.sv
design/spk_out_stage.sv
design/stream_message_packetizer.sv
sim/tb_stream_message_packetizer.sv
